[hw/rtl/sfpa_pkg.sv]
// sfpa_pkg: operation codes and the beat type passed along the divider cell chain
// of the signed fixed-point alu; no dependencies
package sfpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
  } op_t;

  localparam int unsigned NumW = 64;

  typedef struct packed {
    logic            valid;
    logic            is_div;
    logic            neg;
    logic            derr;
    logic            cmp;
    logic [31:0]     res;
    logic [NumW-1:0] quo;
    logic [31:0]     den;
  } beat_t;

endpackage

[hw/rtl/sfpa_cell.sv]
// sfpa_cell: STEPS restoring division steps per cell, registered beat to the next cell
// depends on sfpa_pkg
module sfpa_cell #(
  parameter int unsigned STEPS = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  sfpa_pkg::beat_t d,
  output sfpa_pkg::beat_t q
);

  sfpa_pkg::beat_t b_next;
  logic [32:0]     trial;
  logic [31:0]     r;

  always_comb begin
    b_next = d;
    r = 32'd0;
    trial = 33'd0;
    for (int i = 0; i < STEPS; i++) begin
      r     = b_next.res;
      trial = {r, b_next.quo[sfpa_pkg::NumW-1]} - {1'b0, b_next.den};
      if (!trial[32]) begin
        b_next.res = trial[31:0];
        b_next.quo = {b_next.quo[sfpa_pkg::NumW-2:0], 1'b1};
      end else begin
        b_next.res = {r[30:0], b_next.quo[sfpa_pkg::NumW-1]};
        b_next.quo = {b_next.quo[sfpa_pkg::NumW-2:0], 1'b0};
      end
    end
    if (!d.is_div) b_next = d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= b_next;
    end
  end

endmodule

[hw/rtl/signed_fixed_point_alu.sv]
// signed_fixed_point_alu: top level, front decode, divider cell chain and output stage
// depends on sfpa_pkg and sfpa_cell
// One beat is accepted every cycle while the chain is not stalled; each result passes through
// a front stage, 32 divider cells each retiring two quotient bits of the 64-bit
// dividend, and a final sign/output stage. All modes travel the same chain, so results
// keep order. The chain stalls as a whole only when the output beat is held.
module signed_fixed_point_alu #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         mode,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result_value,
  output logic               compare_flag,
  output logic               divide_error
);

  localparam int unsigned Cells = 32;

  sfpa_pkg::beat_t chain [Cells+1];
  sfpa_pkg::beat_t front_next;
  logic            en;
  logic signed [63:0] prod_s;
  logic [31:0]     mag_a, mag_b;
  logic            is_cmp, c;
  sfpa_pkg::op_t   op;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign op       = sfpa_pkg::op_t'(mode);

  always_comb begin
    mag_a  = operand_a[31] ? 32'd0 - operand_a : operand_a;
    mag_b  = operand_b[31] ? 32'd0 - operand_b : operand_b;
    prod_s = 64'(operand_a) * 64'(operand_b);
    front_next = '0;
    front_next.valid = in_valid;
    is_cmp = 1'b0;
    c = 1'b0;
    unique case (op)
      sfpa_pkg::OP_ADD:      front_next.res = operand_a + operand_b;
      sfpa_pkg::OP_SUB:      front_next.res = operand_a - operand_b;
      sfpa_pkg::OP_MUL:      front_next.res = 32'(prod_s >>> FRAC_BITS);
      sfpa_pkg::OP_DIV: begin
        if (operand_b == 32'sd0) begin
          front_next.derr = 1'b1;
        end else begin
          front_next.is_div = 1'b1;
          front_next.neg    = operand_a[31] ^ operand_b[31];
          front_next.quo    = {32'd0, mag_a} << FRAC_BITS;
          front_next.den    = mag_b;
        end
      end
      sfpa_pkg::OP_GT: begin is_cmp = 1'b1; c = operand_a > operand_b; end
      sfpa_pkg::OP_LT: begin is_cmp = 1'b1; c = operand_a < operand_b; end
      sfpa_pkg::OP_GE: begin is_cmp = 1'b1; c = operand_a >= operand_b; end
      sfpa_pkg::OP_LE: begin is_cmp = 1'b1; c = operand_a <= operand_b; end
      sfpa_pkg::OP_EQ: begin is_cmp = 1'b1; c = operand_a == operand_b; end
      sfpa_pkg::OP_NE: begin is_cmp = 1'b1; c = operand_a != operand_b; end
      sfpa_pkg::OP_MIN:      front_next.res = (operand_a < operand_b) ? operand_a : operand_b;
      sfpa_pkg::OP_MAX:      front_next.res = (operand_a > operand_b) ? operand_a : operand_b;
      sfpa_pkg::OP_INC:      front_next.res = operand_a + 32'sd1;
      sfpa_pkg::OP_DEC:      front_next.res = operand_a - 32'sd1;
      sfpa_pkg::OP_FROM_INT: front_next.res = operand_a << FRAC_BITS;
      sfpa_pkg::OP_TO_INT:   front_next.res = operand_a >>> FRAC_BITS;
      default:               front_next.res = 32'd0;
    endcase
    if (is_cmp) begin
      front_next.cmp = c;
      front_next.res = {31'd0, c};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (en) begin
      chain[0] <= front_next;
    end
  end

  for (genvar g = 0; g < Cells; g++) begin : g_cell
    sfpa_cell #(.STEPS(sfpa_pkg::NumW / Cells)) u_cell (
      .clk(clk), .rst(rst), .en(en), .d(chain[g]), .q(chain[g+1])
    );
  end

  sfpa_pkg::beat_t last;
  logic [31:0]     q_lo;
  assign last = chain[Cells];
  assign q_lo = last.quo[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid    <= last.valid;
      compare_flag <= last.cmp;
      divide_error <= last.derr;
      if (last.is_div) result_value <= last.neg ? 32'd0 - q_lo : q_lo;
      else result_value <= last.res;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_error |-> result_value == 32'sd0 && !compare_flag)
    else $error("divide error with nonzero result");
  a_cmp_val: assert property (@(posedge clk) disable iff (rst)
    out_valid && compare_flag |-> result_value == 32'sd1)
    else $error("compare flag without unit result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value))
    else $error("held output beat changed");

endmodule

[sim/signed_fixed_point_alu_checker.sv]
// checker for signed_fixed_point_alu: watches both channels, predicts each result
// from the operands and compares field by field; depends on sfpa_pkg
`timescale 1ns / 100ps

module signed_fixed_point_alu_checker #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [3:0]         mode,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] result_value,
  input  logic               compare_flag,
  input  logic               divide_error,
  output int                 fail_count,
  output int                 pending,
  output int                 result_count
);

  typedef struct packed {
    logic [31:0] value;
    logic        flag;
    logic        derr;
  } alu_result_t;

  alu_result_t expected_results[$];

  function automatic alu_result_t alu_predict(logic [3:0] m, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_result_t r;
    logic signed [63:0] prod;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    r = '0;
    case (sfpa_pkg::op_t'(m))
      sfpa_pkg::OP_ADD: r.value = a + b;
      sfpa_pkg::OP_SUB: r.value = a - b;
      sfpa_pkg::OP_MUL: begin
        prod = 64'(a) * 64'(b);
        r.value = 32'(prod >>> FRAC_BITS);
      end
      sfpa_pkg::OP_DIV: begin
        if (b == 0) begin
          r.derr = 1'b1;
        end else begin
          num = (a < 0 ? -64'(a) : 64'(a)) << FRAC_BITS;
          den = b < 0 ? -64'(b) : 64'(b);
          quo = num / den;
          if ((a < 0) != (b < 0)) quo = -quo;
          r.value = quo[31:0];
        end
      end
      sfpa_pkg::OP_GT: r.flag = a > b;
      sfpa_pkg::OP_LT: r.flag = a < b;
      sfpa_pkg::OP_GE: r.flag = a >= b;
      sfpa_pkg::OP_LE: r.flag = a <= b;
      sfpa_pkg::OP_EQ: r.flag = a == b;
      sfpa_pkg::OP_NE: r.flag = a != b;
      sfpa_pkg::OP_MIN: r.value = (a < b) ? a : b;
      sfpa_pkg::OP_MAX: r.value = (a > b) ? a : b;
      sfpa_pkg::OP_INC: r.value = a + 1;
      sfpa_pkg::OP_DEC: r.value = a - 1;
      sfpa_pkg::OP_FROM_INT: r.value = a << FRAC_BITS;
      default: r.value = a >>> FRAC_BITS;
    endcase
    if (m inside {[sfpa_pkg::OP_GT:sfpa_pkg::OP_NE]}) r.value = {31'd0, r.flag};
    return r;
  endfunction

  always @(posedge clk) begin
    alu_result_t exp_r;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
      result_count <= 0;
      pending <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(alu_predict(mode, operand_a, operand_b));
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation");
          errs++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result_value !== exp_r.value) begin
            $error("result_value expected %h actual %h", exp_r.value, result_value);
            errs++;
          end
          if (compare_flag !== exp_r.flag) begin
            $error("compare_flag expected %b actual %b", exp_r.flag, compare_flag);
            errs++;
          end
          if (divide_error !== exp_r.derr) begin
            $error("divide_error expected %b actual %b", exp_r.derr, divide_error);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= expected_results.size();
    end
  end
endmodule

[sim/signed_fixed_point_alu_test.sv]
// testbench top for signed_fixed_point_alu: drives operand beats with random gaps
// and output stalls; depends on sfpa_pkg, signed_fixed_point_alu and signed_fixed_point_alu_checker
`timescale 1ns / 100ps

module signed_fixed_point_alu_test;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         mode = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] result_value;
  logic               compare_flag;
  logic               divide_error;
  int                 fail_count;
  int                 pending;
  int                 result_count;
  int                 cycle_count = 0;
  int                 hold_off = 0;

  localparam int CycleLimit = 400000;
  localparam int RandomBeats = 1700;

  signed_fixed_point_alu #(.FRAC_BITS(8)) uut (.*);
  signed_fixed_point_alu_checker #(.FRAC_BITS(8)) chk (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("signed_fixed_point_alu test failed");
      $finish;
    end
  end

  // receiver stalls, with one long hold-off once well into the run
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (result_count == 600 && out_valid && out_ready) begin
      hold_off <= 300;
      out_ready <= 1'b0;
    end else if (cycle_count % 2000 < 400) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 3) begin
      hold_off <= $urandom_range(10, 60);
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(0, 3) != 0;
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h1;
      4: return $urandom_range(0, 1) ? 32'h100 : 32'hffff_ff00;
      5: return 32'($signed($urandom_range(0, 4095)) - 2048);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(logic [3:0] m, logic [31:0] a, logic [31:0] b);
    int gap;
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (cycle_count % 3000 < 500) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    logic [31:0] b;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int m = 0; m < 16; m++)
      send_beat(4'(m), 32'h8000_0000, 32'h7fff_ffff);
    send_beat(sfpa_pkg::OP_DIV, 32'h0000_0500, 32'h0);
    send_beat(sfpa_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_beat(sfpa_pkg::OP_DIV, 32'hffff_fd00, 32'h0000_0200);
    send_beat(sfpa_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    send_beat(sfpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_beat(sfpa_pkg::OP_MIN, 32'h0000_0300, 32'h0000_0300);
    send_beat(sfpa_pkg::OP_MAX, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(sfpa_pkg::OP_TO_INT, 32'hffff_ff01, 32'hffff_ffff);
    send_beat(sfpa_pkg::OP_FROM_INT, 32'h00ff_ffff, 32'h0);
    for (int i = 0; i < RandomBeats; i++) begin
      b = pick_operand();
      if ($urandom_range(0, 15) == 0) b = 32'h0;
      send_beat(4'($urandom_range(0, 15)), pick_operand(), b);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("ran %0d result beats over all 16 modes, with edge operands,", result_count);
    $display("division by zero, input gaps and output hold-offs");
    if (fail_count == 0 && pending == 0) begin
      $display("signed_fixed_point_alu test passed");
    end else begin
      $display("signed_fixed_point_alu test failed");
    end
    $finish;
  end
endmodule
